### rtl/pmct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_pkg
// shared widths, reset values, register codes and control structs of the
// ps/2 mouse cursor tracker
// ----------------------------------------------------------------------------
package pmct_pkg;

  localparam int TerminalsDef = 3;

  localparam int ByteW = 8;
  localparam int TermW = 2;
  localparam int MagW  = 16;   // magnitude after the multiply, up to 256 * 255
  localparam int CfgIdxW = 3;

  localparam logic [ByteW-1:0] ColsRst = 8'd80;
  localparam logic [ByteW-1:0] RowsRst = 8'd25;
  localparam logic [ByteW-1:0] DivRst  = 8'h01;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_COLUMNS  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROWS     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_X_DIV    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_Y_DIV    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MOTION   = 3'd4;

  // header bits of a packet
  localparam int HdrSignX = 4;
  localparam int HdrSignY = 5;
  localparam int HdrOvfX  = 6;
  localparam int HdrOvfY  = 7;

  typedef struct packed {
    logic ld_hdr;      // capture header byte
    logic ld_xb;       // capture x delta byte
    logic ld_pkt;      // capture y delta and terminal, packet goes to work
    logic div_start;   // launch the divider
    logic div_stage2;  // dividend is the product, divisor the motion divisor
    logic axis_y;      // operate on the y axis
    logic take_q;      // load quotient into the magnitude register
    logic mul;         // multiply magnitude by column or row count
    logic fin;         // add move and clamp
    logic commit;      // write stores and present the result
  } pmct_cmd_t;

  typedef struct packed {
    logic pkt_drop;    // third byte completes a packet that gives no result
    logic div_done;    // quotient ready
    logic out_free;    // result register can take a new item
  } pmct_sts_t;

endpackage

### rtl/pmct_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pmct_div
  import pmct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MagW-1:0]  dividend,
  input  logic [ByteW-1:0] divisor,
  output logic             done,
  output logic [MagW-1:0]  quotient
);

  localparam int CntW = $clog2(MagW + 1);

  logic [MagW-1:0]  quo_r;
  logic [ByteW-1:0] rem_r;
  logic [ByteW-1:0] dvs_r;
  logic [CntW-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [ByteW:0]   trial;
  logic [ByteW:0]   diff;
  logic             ge;
  logic [ByteW-1:0] rem_nxt;

  assign trial   = {rem_r, quo_r[MagW-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign ge      = (trial >= {1'b0, dvs_r});
  assign rem_nxt = ge ? diff[ByteW-1:0] : trial[ByteW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(MagW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      // a zero divisor acts as one
      dvs_r <= (divisor == '0) ? ByteW'(1) : divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[MagW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/pmct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_ctrl
// packet phase tracking and the sequencer of the scaling steps
// ----------------------------------------------------------------------------
module pmct_ctrl
  import pmct_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pmct_sts_t sts,
  output pmct_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LX1  = 4'd1;
  localparam logic [3:0] S_WX1  = 4'd2;
  localparam logic [3:0] S_MX   = 4'd3;
  localparam logic [3:0] S_LX2  = 4'd4;
  localparam logic [3:0] S_WX2  = 4'd5;
  localparam logic [3:0] S_FX   = 4'd6;
  localparam logic [3:0] S_LY1  = 4'd7;
  localparam logic [3:0] S_WY1  = 4'd8;
  localparam logic [3:0] S_MY   = 4'd9;
  localparam logic [3:0] S_LY2  = 4'd10;
  localparam logic [3:0] S_WY2  = 4'd11;
  localparam logic [3:0] S_FY   = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_X   = 2'd1;
  localparam logic [1:0] PH_Y   = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (phase_r)
            PH_X: begin
              cmd.ld_xb = 1'b1;
              phase_nxt = PH_Y;
            end
            PH_Y: begin
              phase_nxt = PH_HDR;
              if (!sts.pkt_drop) begin
                cmd.ld_pkt = 1'b1;
                state_nxt  = S_LX1;
              end
            end
            default: begin
              cmd.ld_hdr = 1'b1;
              phase_nxt  = PH_X;
            end
          endcase
        end
      end
      S_LX1: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WX1;
      end
      S_WX1: begin
        if (sts.div_done) begin
          cmd.take_q = 1'b1;
          state_nxt  = S_MX;
        end
      end
      S_MX: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LX2;
      end
      S_LX2: begin
        cmd.div_start  = 1'b1;
        cmd.div_stage2 = 1'b1;
        state_nxt      = S_WX2;
      end
      S_WX2: begin
        if (sts.div_done) begin
          cmd.take_q = 1'b1;
          state_nxt  = S_FX;
        end
      end
      S_FX: begin
        cmd.fin   = 1'b1;
        state_nxt = S_LY1;
      end
      S_LY1: begin
        cmd.div_start = 1'b1;
        cmd.axis_y    = 1'b1;
        state_nxt     = S_WY1;
      end
      S_WY1: begin
        cmd.axis_y = 1'b1;
        if (sts.div_done) begin
          cmd.take_q = 1'b1;
          state_nxt  = S_MY;
        end
      end
      S_MY: begin
        cmd.mul    = 1'b1;
        cmd.axis_y = 1'b1;
        state_nxt  = S_LY2;
      end
      S_LY2: begin
        cmd.div_start  = 1'b1;
        cmd.div_stage2 = 1'b1;
        cmd.axis_y     = 1'b1;
        state_nxt      = S_WY2;
      end
      S_WY2: begin
        cmd.axis_y = 1'b1;
        if (sts.div_done) begin
          cmd.take_q = 1'b1;
          state_nxt  = S_FY;
        end
      end
      S_FY: begin
        cmd.fin    = 1'b1;
        cmd.axis_y = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_HDR;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

### rtl/pmct_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmct_dp
// packet registers, configuration, scaling datapath, cursor stores and the
// result register
// ----------------------------------------------------------------------------
module pmct_dp
  import pmct_pkg::*;
#(
  parameter int TERMINALS = TerminalsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data,
  input  logic [ByteW-1:0]   in_rx_byte,
  input  logic [TermW-1:0]   in_terminal,
  input  pmct_cmd_t          cmd,
  output pmct_sts_t          sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ByteW-1:0]   out_cursor_x,
  output logic [ByteW-1:0]   out_cursor_y,
  output logic [ByteW-1:0]   out_prev_x,
  output logic [ByteW-1:0]   out_prev_y,
  output logic               out_first_move,
  output logic [TermW-1:0]   out_term_out
);

  localparam int TermIdxW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int SumW     = MagW + 2;

  // configuration
  logic [ByteW-1:0] cols_r, rows_r, xdiv_r, ydiv_r, mdiv_r;

  // packet
  logic [ByteW-1:0]    hdr_r;
  logic [ByteW-1:0]    xbyte_r;
  logic [ByteW:0]      ymag_r;
  logic                ysign_r;
  logic [TermIdxW-1:0] tidx_r;

  // work registers
  logic [MagW-1:0]  mag_r;
  logic [ByteW-1:0] newx_r, newy_r;

  // cursor stores
  logic [ByteW-1:0] pos_x_r [TERMINALS];
  logic [ByteW-1:0] pos_y_r [TERMINALS];
  logic             first_r [TERMINALS];

  // result register
  logic             out_valid_r;
  logic [ByteW-1:0] cur_x_r, cur_y_r, prev_x_r, prev_y_r;
  logic             first_out_r;
  logic [TermW-1:0] term_out_r;

  logic [ByteW:0]     xmag, ymag_in;
  logic               xsign;
  logic               term_ok;
  logic [MagW-1:0]    div_dividend;
  logic [ByteW-1:0]   div_divisor;
  logic               div_done;
  logic [MagW-1:0]    div_q;
  logic [ByteW-1:0]   count;
  logic [MagW:0]      prod;
  logic [ByteW-1:0]   pos_sel;
  logic               neg_move;
  logic signed [SumW-1:0] base, move, sum;
  logic [ByteW-1:0]   clamped;

  // 9-bit two's complement delta to sign and magnitude
  function automatic logic [ByteW:0] mag9(input logic [ByteW-1:0] low, input logic neg);
    mag9 = neg ? ((ByteW+1)'(256) - {1'b0, low}) : {1'b0, low};
  endfunction

  function automatic logic [ByteW-1:0] clamp(input logic signed [SumW-1:0] v,
                                             input logic [ByteW-1:0] cnt);
    logic [ByteW-1:0] lim;
    lim = (cnt == '0) ? '0 : cnt - 1'b1;
    if (v < 0)
      clamp = '0;
    else if (v > $signed({{(SumW-ByteW){1'b0}}, lim}))
      clamp = lim;
    else
      clamp = v[ByteW-1:0];
  endfunction

  assign xsign   = hdr_r[HdrSignX];
  assign xmag    = mag9(xbyte_r, xsign);
  assign ymag_in = mag9(in_rx_byte, hdr_r[HdrSignY]);
  assign term_ok = (32'(in_terminal) < TERMINALS);

  assign sts.pkt_drop = hdr_r[HdrOvfX] || hdr_r[HdrOvfY] ||
                        ((xmag == '0) && (ymag_in == '0)) || !term_ok;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  // divider operand selection
  always_comb begin
    if (cmd.div_stage2) begin
      div_dividend = mag_r;
      div_divisor  = mdiv_r;
    end else if (cmd.axis_y) begin
      div_dividend = MagW'(ymag_r);
      div_divisor  = ydiv_r;
    end else begin
      div_dividend = MagW'(xmag);
      div_divisor  = xdiv_r;
    end
  end

  pmct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // first quotient is at most 256, so nine bits feed the multiplier
  assign count = cmd.axis_y ? rows_r : cols_r;
  assign prod  = mag_r[ByteW:0] * count;

  // x moves by +delta, y by -delta
  assign pos_sel  = cmd.axis_y ? pos_y_r[tidx_r] : pos_x_r[tidx_r];
  assign neg_move = cmd.axis_y ? !ysign_r : xsign;
  assign base     = $signed({{(SumW-ByteW){1'b0}}, pos_sel});
  assign move     = $signed({2'b00, mag_r});
  assign sum      = neg_move ? (base - move) : (base + move);
  assign clamped  = clamp(sum, count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= ColsRst;
      rows_r <= RowsRst;
      xdiv_r <= DivRst;
      ydiv_r <= DivRst;
      mdiv_r <= DivRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS: cols_r <= cfg_data;
        CFG_ROWS:    rows_r <= cfg_data;
        CFG_X_DIV:   xdiv_r <= cfg_data;
        CFG_Y_DIV:   ydiv_r <= cfg_data;
        CFG_MOTION:  mdiv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r   <= '0;
      xbyte_r <= '0;
    end else begin
      if (cmd.ld_hdr) hdr_r   <= in_rx_byte;
      if (cmd.ld_xb)  xbyte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_pkt) begin
      ymag_r  <= ymag_in;
      ysign_r <= hdr_r[HdrSignY];
      tidx_r  <= TermIdxW'(in_terminal);
    end
    if (cmd.take_q) mag_r <= div_q;
    else if (cmd.mul) mag_r <= prod[MagW-1:0];
    if (cmd.fin && !cmd.axis_y) newx_r <= clamped;
    if (cmd.fin && cmd.axis_y)  newy_r <= clamped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TERMINALS; i++) begin
        pos_x_r[i] <= '0;
        pos_y_r[i] <= '0;
        first_r[i] <= 1'b1;
      end
    end else if (cmd.commit) begin
      pos_x_r[tidx_r] <= newx_r;
      pos_y_r[tidx_r] <= newy_r;
      first_r[tidx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      cur_x_r     <= newx_r;
      cur_y_r     <= newy_r;
      prev_x_r    <= pos_x_r[tidx_r];
      prev_y_r    <= pos_y_r[tidx_r];
      first_out_r <= first_r[tidx_r];
      term_out_r  <= TermW'(tidx_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_x   = cur_x_r;
  assign out_cursor_y   = cur_y_r;
  assign out_prev_x     = prev_x_r;
  assign out_prev_y     = prev_y_r;
  assign out_first_move = first_out_r;
  assign out_term_out   = term_out_r;

endmodule

### rtl/ps2_mouse_cursor_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// ps/2 mouse packet decoder that moves per-terminal text cursors
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one mouse byte per item plus the terminal index, which is
//   looked at on the third byte of a packet. header and x delta bytes are
//   taken without a stall. a third byte that completes a usable packet keeps
//   in_stall high through four 16-step divisions on the shared bit-serial
//   divider (each with launch and hand-off), two multiply steps, two
//   add-and-clamp steps and the commit.
//   out_* gives one item per packet with a nonzero delta; overflow packets,
//   zero packets and out-of-range terminals give nothing and do not stall.
//   the result sits in an output register: a new byte is taken while it
//   waits, and only a second result waits (in_stall stays high) until
//   out_stall drops. cfg_we writes one of five 8-bit registers by cfg_index;
//   the user writes them only while idle, which the block leaves unenforced.
//   reset (rst_n low, synchronous) restores 80x25 screen, divisors of one,
//   cursors at zero and every terminal marked as not yet moved.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker
  import pmct_pkg::*;
#(
  parameter int TERMINALS = TerminalsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data,
  // mouse bytes
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ByteW-1:0]   in_rx_byte,
  input  logic [TermW-1:0]   in_terminal,
  // cursor moves
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ByteW-1:0]   out_cursor_x,
  output logic [ByteW-1:0]   out_cursor_y,
  output logic [ByteW-1:0]   out_prev_x,
  output logic [ByteW-1:0]   out_prev_y,
  output logic               out_first_move,
  output logic [TermW-1:0]   out_term_out
);

  pmct_cmd_t cmd;
  pmct_sts_t sts;

  // sequencer: byte phase and scaling steps
  pmct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: packet registers, divider, multiplier, clamp, stores
  pmct_dp #(
    .TERMINALS (TERMINALS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_rx_byte     (in_rx_byte),
    .in_terminal    (in_terminal),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_x   (out_cursor_x),
    .out_cursor_y   (out_cursor_y),
    .out_prev_x     (out_prev_x),
    .out_prev_y     (out_prev_y),
    .out_first_move (out_first_move),
    .out_term_out   (out_term_out)
  );

endmodule
